@@ rtl/jts_pkg.sv @@
// Shared types, codes and character constants for the JSON token serializer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package jts_pkg;

  localparam int MAX_LEVEL_DEF = 7;

  // Token command codes.
  localparam logic [3:0] CMD_CLEAR     = 4'd0;
  localparam logic [3:0] CMD_INTEGER   = 4'd1;
  localparam logic [3:0] CMD_STR_OPEN  = 4'd2;
  localparam logic [3:0] CMD_ESC_CHAR  = 4'd3;
  localparam logic [3:0] CMD_RAW_CHAR  = 4'd4;
  localparam logic [3:0] CMD_STR_CLOSE = 4'd5;
  localparam logic [3:0] CMD_OBJ_BEGIN = 4'd6;
  localparam logic [3:0] CMD_OBJ_END   = 4'd7;
  localparam logic [3:0] CMD_KEY_OPEN  = 4'd8;
  localparam logic [3:0] CMD_KEY_CLOSE = 4'd9;
  localparam logic [3:0] CMD_ARR_BEGIN = 4'd10;
  localparam logic [3:0] CMD_ARR_END   = 4'd11;

  // Per-level nesting state codes.
  typedef logic [2:0] lvl_t;
  localparam lvl_t LS_INIT         = 3'd0;
  localparam lvl_t LS_ARRAY_FIRST  = 3'd1;
  localparam lvl_t LS_ARRAY_NEXT   = 3'd2;
  localparam lvl_t LS_OBJECT_FIRST = 3'd3;
  localparam lvl_t LS_OBJECT_NEXT  = 3'd4;

  // Characters of the output text.
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          DIG_DEPTH   = 10;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic pop_load;
    logic div_mul;
    logic div_rem;
    logic emit_fix;
    logic emit_dig;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       plan_pop;
    logic       plan_int;
    logic [1:0] plan_nfix;
    logic       int_r;
    logic       nfix_zero;
    logic       quot_zero;
    logic       fix_last;
    logic       dig_last;
    logic       out_free;
  } dp_stat_t;

  // Second byte of an escape sequence.
  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h5C:   r = CH_BSLASH;
      8'h22:   r = CH_QUOTE;
      8'h08:   r = 8'h62;
      8'h0C:   r = 8'h66;
      8'h0A:   r = 8'h6E;
      8'h0D:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = CH_SLASH;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/jts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the saved nesting states of the serializer.
`timescale 1ns / 1ps

module jts_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/jts_datapath.sv @@
// Datapath: nesting stack, token byte plan, decimal converter and output register.
// Depends on jts_pkg and jts_ram; driven by jts_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module jts_datapath import jts_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_operand,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam int DW = $clog2(DIG_DEPTH);

  // Control state.
  logic [LW-1:0] level_r, level_nxt;
  lvl_t          cur_r, cur_nxt;
  logic          out_valid_r;
  logic [DW-1:0] dig_cnt_r;
  logic          fix_cnt_r;

  // Payload state.
  logic [7:0]  fix0_r, fix1_r;
  logic [1:0]  nfix_r;
  logic        int_r;
  logic [31:0] mag_r;
  logic [31:0] quot_r;
  logic [3:0]  dig_r [DIG_DEPTH];
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  // Stack memory.
  logic          ram_we, ram_re;
  lvl_t          ram_rdata;
  logic [LW-1:0] ram_raddr;

  // Plan for the token at the input.
  logic        comma, neg, plain;
  logic [7:0]  ch, m0, m1, pb0, pb1;
  logic [1:0]  nmain, pn;
  logic        pl_pop, pl_int;
  logic [31:0] opnd_u, mag_in;

  logic [63:0] prod;
  logic [31:0] rem_full;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        out_free;

  assign opnd_u = unsigned'(in_operand);
  assign neg    = in_operand[31];
  assign mag_in = neg ? (32'd0 - opnd_u) : opnd_u;
  assign ch     = in_operand[7:0];
  assign plain  = (ch >= CH_SPACE) && (ch != CH_BSLASH) && (ch != CH_QUOTE);

  always_comb begin
    comma  = 1'b0;
    m0     = 8'd0;
    m1     = 8'd0;
    nmain  = 2'd0;
    pl_pop = 1'b0;
    pl_int = 1'b0;
    case (in_command)
      CMD_INTEGER: begin
        comma  = (cur_r == LS_ARRAY_NEXT);
        m0     = CH_MINUS;
        nmain  = {1'b0, neg};
        pl_int = 1'b1;
      end
      CMD_STR_OPEN: begin
        comma = (cur_r == LS_ARRAY_NEXT);
        m0    = CH_QUOTE;
        nmain = 2'd1;
      end
      CMD_ESC_CHAR: begin
        if (plain) begin
          m0    = ch;
          nmain = 2'd1;
        end else begin
          m0    = CH_BSLASH;
          m1    = esc_code(ch);
          nmain = 2'd2;
        end
      end
      CMD_RAW_CHAR: begin
        m0    = ch;
        nmain = 2'd1;
      end
      CMD_STR_CLOSE: begin
        m0    = CH_QUOTE;
        nmain = 2'd1;
      end
      CMD_OBJ_BEGIN: begin
        comma = (cur_r == LS_ARRAY_NEXT);
        m0    = CH_LBRACE;
        nmain = 2'd1;
      end
      CMD_OBJ_END: begin
        m0     = CH_RBRACE;
        nmain  = 2'd1;
        pl_pop = (level_r != '0);
      end
      CMD_KEY_OPEN: begin
        comma = (cur_r == LS_OBJECT_NEXT);
        m0    = CH_QUOTE;
        nmain = 2'd1;
      end
      CMD_KEY_CLOSE: begin
        m0    = CH_QUOTE;
        m1    = CH_COLON;
        nmain = 2'd2;
      end
      CMD_ARR_BEGIN: begin
        comma = (cur_r == LS_ARRAY_NEXT);
        m0    = CH_LBRACK;
        nmain = 2'd1;
      end
      CMD_ARR_END: begin
        m0     = CH_RBRACK;
        nmain  = 2'd1;
        pl_pop = (level_r != '0);
      end
      default: begin
      end
    endcase
    // A comma never precedes more than one main byte.
    if (comma) begin
      pb0 = CH_COMMA;
      pb1 = m0;
      pn  = nmain + 2'd1;
    end else begin
      pb0 = m0;
      pb1 = m1;
      pn  = nmain;
    end
  end

  // Nesting stack update. The current level's state lives in cur_r; the
  // states of enclosing levels are saved in the memory on a push.
  always_comb begin
    cur_nxt   = cur_r;
    level_nxt = level_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = level_r - LW'(1);
    if (cmd.accept) begin
      case (in_command)
        CMD_CLEAR: begin
          level_nxt = '0;
          cur_nxt   = LS_INIT;
        end
        CMD_INTEGER, CMD_STR_CLOSE: begin
          if (cur_r == LS_ARRAY_FIRST) begin
            cur_nxt = LS_ARRAY_NEXT;
          end
        end
        CMD_OBJ_BEGIN, CMD_ARR_BEGIN: begin
          if (level_r != LW'(MAX_LEVEL)) begin
            ram_we    = 1'b1;
            level_nxt = level_r + LW'(1);
            cur_nxt   = (in_command == CMD_OBJ_BEGIN) ? LS_OBJECT_FIRST : LS_ARRAY_FIRST;
          end
        end
        CMD_OBJ_END, CMD_ARR_END: begin
          if (level_r != '0) begin
            ram_re    = 1'b1;
            level_nxt = level_r - LW'(1);
          end else if (cur_r == LS_ARRAY_FIRST) begin
            cur_nxt = LS_ARRAY_NEXT;
          end
        end
        CMD_KEY_OPEN: begin
          cur_nxt = LS_OBJECT_NEXT;
        end
        default: begin
        end
      endcase
    end else if (cmd.pop_load) begin
      cur_nxt = (ram_rdata == LS_ARRAY_FIRST) ? LS_ARRAY_NEXT : ram_rdata;
    end
  end

  jts_ram #(
    .WIDTH ($bits(lvl_t)),
    .DEPTH (MAX_LEVEL + 1)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (level_r),
    .wr_data (cur_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Divide by ten: the multiply is registered, the remainder follows next cycle.
  assign prod     = {32'd0, mag_r} * {32'd0, RECIP10};
  assign rem_full = mag_r - ((quot_r << 3) + (quot_r << 1));

  always_comb begin
    if (cmd.emit_dig) begin
      emit_byte = CH_ZERO + {4'd0, dig_r[dig_cnt_r - DW'(1)]};
      emit_last = (dig_cnt_r == DW'(1));
    end else begin
      emit_byte = fix_cnt_r ? fix1_r : fix0_r;
      emit_last = (fix_cnt_r == (nfix_r == 2'd2)) && !int_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      cur_r       <= LS_INIT;
      out_valid_r <= 1'b0;
      dig_cnt_r   <= '0;
      fix_cnt_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      cur_r   <= cur_nxt;
      if (cmd.emit_fix || cmd.emit_dig) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        dig_cnt_r <= '0;
        fix_cnt_r <= 1'b0;
      end else if (cmd.div_rem) begin
        dig_cnt_r <= dig_cnt_r + DW'(1);
      end else if (cmd.emit_dig) begin
        dig_cnt_r <= dig_cnt_r - DW'(1);
      end else if (cmd.emit_fix) begin
        fix_cnt_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fix0_r <= pb0;
      fix1_r <= pb1;
      nfix_r <= pn;
      int_r  <= pl_int;
      mag_r  <= mag_in;
    end
    if (cmd.div_mul) begin
      quot_r <= 32'(prod[63:RECIP_SHIFT]);
    end
    if (cmd.div_rem) begin
      dig_r[dig_cnt_r] <= rem_full[3:0];
      mag_r            <= quot_r;
    end
    if (cmd.emit_fix || cmd.emit_dig) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign stat.plan_pop  = pl_pop;
  assign stat.plan_int  = pl_int;
  assign stat.plan_nfix = pn;
  assign stat.int_r     = int_r;
  assign stat.nfix_zero = (nfix_r == 2'd0);
  assign stat.quot_zero = (quot_r == 32'd0);
  assign stat.fix_last  = (fix_cnt_r == (nfix_r == 2'd2));
  assign stat.dig_last  = (dig_cnt_r == DW'(1));
  assign stat.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/jts_ctrl.sv @@
// Controller state machine of the JSON token serializer.
// Depends on jts_pkg; steers jts_datapath through dp_cmd_t and dp_stat_t.
`timescale 1ns / 1ps

module jts_ctrl import jts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.plan_pop) begin
            state_nxt = S_POP;
          end else if (stat.plan_int) begin
            state_nxt = S_MUL;
          end else if (stat.plan_nfix != 2'd0) begin
            state_nxt = S_FIX;
          end
        end
      end
      S_POP: begin
        // The saved state of the enclosing level arrives from the stack memory.
        cmd.pop_load = 1'b1;
        state_nxt    = S_FIX;
      end
      S_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_REM;
      end
      S_REM: begin
        cmd.div_rem = 1'b1;
        if (!stat.quot_zero) begin
          state_nxt = S_MUL;
        end else if (stat.nfix_zero) begin
          state_nxt = S_DIG;
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (stat.out_free) begin
          cmd.emit_fix = 1'b1;
          if (stat.fix_last) begin
            state_nxt = stat.int_r ? S_DIG : S_IDLE;
          end
        end
      end
      S_DIG: begin
        if (stat.out_free) begin
          cmd.emit_dig = 1'b1;
          if (stat.dig_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/json_token_serializer.sv @@
// Top level of the JSON token serializer: controller, datapath and checks.
// Depends on jts_pkg, jts_ctrl, jts_datapath and jts_ram.
`timescale 1ns / 1ps

// One JSON writer token is taken per input word and its text leaves as bytes, one
// output word per cycle while the output is not stalled, the final byte of each
// token marked by out_last. An object or array end that closes a nested level
// first reads the saved level state from the stack memory. An integer first
// passes through the divide-by-ten unit, a reciprocal multiply and then the
// remainder for each decimal digit, before its comma, minus sign and digits are
// sent. Clear and the unused command codes emit nothing. A new token is taken
// while the last byte of the previous one still waits in the output register.
module json_token_serializer import jts_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  jts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  jts_datapath #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_command),
    .in_operand (in_operand),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  // A byte is never loaded over a word that is still held by the receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_fix || cmd.emit_dig) |-> !(out_valid && out_stall))
    else $error("output word overwritten while stalled");

  // A token that emits nothing leaves the block ready in the next cycle.
  a_empty_token: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !stat.plan_pop && !stat.plan_int && stat.plan_nfix == 2'd0)
    |=> !in_stall)
    else $error("empty token did not return to ready");

  // The final digit of an integer ends the token and is marked as last.
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_dig && stat.dig_last) |=> (!in_stall && out_valid && out_last))
    else $error("final digit not marked or block not ready");

endmodule
